>>> src/mhs_pkg.sv
// ----------------------------------------------------------------------------
// mhs_pkg: shared definitions for the magnetic hysteresis saturator
// Register indexes, reset values, the configuration record and the table
// of Q30 square roots of two used by the exp2 iteration.
// ----------------------------------------------------------------------------
package mhs_pkg;

  localparam int CHANNELS_DEF    = 2;
  localparam int SAMPLE_BITS_DEF = 16;

  // Width of every per-lane state value (signed, 16 fractional bits).
  localparam int ST_W    = 24;
  // Width of the curve result (signed magnitude up to 2^24).
  localparam int CURVE_W = 25;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_EXP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KNEE_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KNEE_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO   = 3'd6;

  localparam logic [7:0]  DRIVE_RST    = 8'd8;
  localparam logic [14:0] EXPONENT_RST = 15'd7373;
  localparam logic [18:0] INV_EXP_RST  = 19'd36409;
  localparam logic [21:0] KNEE_X_RST   = 22'd98304;
  localparam logic [16:0] KNEE_Y_RST   = 17'd52679;
  localparam logic [6:0]  LEVEL_RST    = 7'd64;
  localparam logic        STEREO_RST   = 1'b1;

  typedef struct packed {
    logic [7:0]  drive;
    logic [14:0] p;
    logic [18:0] inv;
    logic [21:0] knee_x;
    logic [16:0] knee_y;
    logic [6:0]  level;
    logic        stereo;
  } mhs_cfg_t;

  typedef logic signed [ST_W-1:0] mhs_st_t;

  typedef logic [15:0][30:0] root_tab_t;

  // Floor square root, bit by bit; evaluated at elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    int          i;
    r   = 64'd0;
    rem = n;
    b   = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Entry i holds 2^(2^-(i+1)) in Q30, each the floor root of the one before.
  function automatic root_tab_t build_roots();
    root_tab_t   tab;
    logic [63:0] c;
    int          i;
    c      = isqrt64(64'd2 << 60);
    tab[0] = c[30:0];
    for (i = 1; i < 16; i++) begin
      c      = isqrt64(c << 30);
      tab[i] = c[30:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

endpackage

>>> src/mhs_curve.sv
// ----------------------------------------------------------------------------
// mhs_curve: iterative evaluation of z / (1 + |z|^p)^(1/p)
// One shared step unit: a normalise pass, up to two log2 passes by repeated
// squaring and two exp2 passes over the root table, one step per cycle.
// ----------------------------------------------------------------------------
module mhs_curve (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [mhs_pkg::ST_W-1:0]      z,
  input  logic [14:0]                          p,
  input  logic [18:0]                          inv,
  output logic                                 done,
  output logic signed [mhs_pkg::CURVE_W-1:0]   c
);

  localparam logic [3:0] C_IDLE  = 4'd0;
  localparam logic [3:0] C_NORM  = 4'd1;
  localparam logic [3:0] C_LOG   = 4'd2;
  localparam logic [3:0] C_TMUL  = 4'd3;
  localparam logic [3:0] C_WPREP = 4'd4;
  localparam logic [3:0] C_EXP   = 4'd5;
  localparam logic [3:0] C_EXPSH = 4'd6;
  localparam logic [3:0] C_SPMUL = 4'd7;
  localparam logic [3:0] C_EPREP = 4'd8;

  localparam logic [3:0] NORM_LAST = 4'd4;
  localparam logic [3:0] STEP_LAST = 4'd15;

  logic [3:0]         state;
  logic [3:0]         step;
  logic               second;
  logic               neg;
  logic [23:0]        v;
  logic [4:0]         lz;
  logic [31:0]        m;
  logic [15:0]        lfrac;
  logic signed [20:0] lg;
  logic signed [24:0] t;
  logic signed [28:0] e;
  logic [30:0]        r;
  logic [24:0]        sp;
  logic [27:0]        u;

  logic [24:0]        z_abs;
  logic [4:0]         nsh;
  logic               norm_hit;
  logic [23:0]        norm_v;
  logic [4:0]         norm_lz;
  logic [61:0]        sq;
  logic [31:0]        sqs;
  logic [31:0]        m_next;
  logic [15:0]        lfrac_next;
  logic [61:0]        rp;
  logic [15:0]        f;
  logic [30:0]        r_next;
  logic signed [12:0] n;
  logic signed [14:0] sh;
  logic [30:0]        exp_res;
  logic signed [5:0]  lg_int;
  logic signed [36:0] tprod;
  logic [24:0]        t_abs;
  logic [23:0]        tpos;
  logic [31:0]        m_w;
  logic [43:0]        uprod;

  assign z_abs = z[mhs_pkg::ST_W-1] ? (25'd0 - {z[mhs_pkg::ST_W-1], z}) : {1'b0, z};

  // Leading-zero search in halving strides: 16, 8, 4, 2, 1.
  assign nsh      = 5'd16 >> step[2:0];
  assign norm_hit = (v >> (5'd24 - nsh)) == 24'd0;
  assign norm_v   = norm_hit ? (v << nsh) : v;
  assign norm_lz  = norm_hit ? (lz + nsh) : lz;

  assign sq         = m[30:0] * m[30:0];
  assign sqs        = sq[61:30];
  assign m_next     = sqs[31] ? {1'b0, sqs[31:1]} : sqs;
  assign lfrac_next = lfrac | (sqs[31] ? (16'h8000 >> step) : 16'd0);

  assign f      = e[15:0];
  assign rp     = r * mhs_pkg::ROOT_TAB[step];
  assign r_next = f[4'd15 - step] ? rp[60:30] : r;

  // Final scaling: 30 fractional bits on the first pass, 16 on the second.
  assign n       = e[28:16];
  assign sh      = (second ? 15'sd14 : 15'sd0) - {{2{n[12]}}, n};
  assign exp_res = (sh < 15'sd0) ? r : ((sh >= 15'sd31) ? 31'd0 : (r >> sh[4:0]));

  assign lg_int = 6'sd7 - $signed({1'b0, lz});
  assign tprod  = lg * $signed({1'b0, p});
  assign t_abs  = t[24] ? 25'(-t) : 25'(t);
  assign tpos   = t[24] ? 24'd0 : t[23:0];
  assign m_w    = 32'h4000_0000 + {1'b0, exp_res};
  assign uprod  = sp * inv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= C_IDLE;
      step   <= 4'd0;
      second <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= (state == C_IDLE && start && z_abs == 25'd0) ||
              (state == C_EXPSH && second);
      case (state)
        C_IDLE: begin
          if (start) begin
            if (z_abs == 25'd0) begin
              c <= '0;
            end else begin
              neg    <= z[mhs_pkg::ST_W-1];
              v      <= z_abs[23:0];
              lz     <= 5'd0;
              step   <= 4'd0;
              second <= 1'b0;
              state  <= C_NORM;
            end
          end
        end
        C_NORM: begin
          v  <= norm_v;
          lz <= norm_lz;
          if (step == NORM_LAST) begin
            m     <= {1'b0, norm_v, 7'b0};
            lfrac <= 16'd0;
            step  <= 4'd0;
            state <= C_LOG;
          end else begin
            step <= step + 4'd1;
          end
        end
        C_LOG: begin
          m     <= m_next;
          lfrac <= lfrac_next;
          step  <= step + 4'd1;
          if (step == STEP_LAST) begin
            if (!second) begin
              lg    <= {lg_int[4:0], lfrac_next};
              state <= C_TMUL;
            end else begin
              sp    <= {1'b0, tpos} + {9'd0, lfrac_next};
              state <= C_SPMUL;
            end
          end
        end
        C_TMUL: begin
          t     <= tprod[36:12];
          state <= C_WPREP;
        end
        C_WPREP: begin
          e     <= 29'sd0 - $signed({4'd0, t_abs});
          r     <= 31'h4000_0000;
          step  <= 4'd0;
          state <= C_EXP;
        end
        C_EXP: begin
          r    <= r_next;
          step <= step + 4'd1;
          if (step == STEP_LAST) begin
            state <= C_EXPSH;
          end
        end
        C_EXPSH: begin
          if (!second) begin
            second <= 1'b1;
            if (m_w[31]) begin
              // log2 of exactly two: one whole unit.
              sp    <= {1'b0, tpos} + 25'h1_0000;
              state <= C_SPMUL;
            end else begin
              m     <= m_w;
              lfrac <= 16'd0;
              step  <= 4'd0;
              state <= C_LOG;
            end
          end else begin
            c     <= neg ? -$signed({1'b0, exp_res[23:0]}) : $signed({1'b0, exp_res[23:0]});
            state <= C_IDLE;
          end
        end
        C_SPMUL: begin
          u     <= uprod[43:16];
          state <= C_EPREP;
        end
        C_EPREP: begin
          e     <= $signed({{8{lg[20]}}, lg}) - $signed({1'b0, u});
          r     <= 31'h4000_0000;
          step  <= 4'd0;
          state <= C_EXP;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/mhs_lane.sv
// ----------------------------------------------------------------------------
// mhs_lane: one channel of the hysteresis saturator
// Drive scaling, slope tracking and re-anchoring, the curve unit and the
// output scale and offset; holds the lane state between frames.
// ----------------------------------------------------------------------------
module mhs_lane #(
  parameter int SAMPLE_BITS = mhs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SAMPLE_BITS:0] sample,
  input  mhs_pkg::mhs_cfg_t          cfg,
  output logic                       done,
  output mhs_pkg::mhs_st_t           y
);

  localparam int PROD_W = SAMPLE_BITS + 11;
  localparam int WIDE_W = PROD_W + 16;

  localparam logic [2:0] L_IDLE   = 3'd0;
  localparam logic [2:0] L_X      = 3'd1;
  localparam logic [2:0] L_ANCHOR = 3'd2;
  localparam logic [2:0] L_SHIFT  = 3'd3;
  localparam logic [2:0] L_OSH    = 3'd4;
  localparam logic [2:0] L_CURVE  = 3'd5;
  localparam logic [2:0] L_OUT    = 3'd6;

  function automatic mhs_pkg::mhs_st_t sat24(input logic signed [63:0] val);
    mhs_pkg::mhs_st_t res;
    if (val > 64'sd8388607) begin
      res = 24'sh7F_FFFF;
    end else if (val < -64'sd8388608) begin
      res = 24'sh80_0000;
    end else begin
      res = val[23:0];
    end
    return res;
  endfunction

  logic [2:0]                 state;
  logic signed [PROD_W-1:0]   sprod;
  mhs_pkg::mhs_st_t           x;
  mhs_pkg::mhs_st_t           prev_input;
  mhs_pkg::mhs_st_t           prev_slope;
  mhs_pkg::mhs_st_t           curve_output;
  mhs_pkg::mhs_st_t           input_shift;
  mhs_pkg::mhs_st_t           output_scale;
  mhs_pkg::mhs_st_t           output_shift;
  mhs_pkg::mhs_st_t           z;
  logic                       from_rise;
  logic                       anchor;
  logic signed [41:0]         kprod;
  logic signed [48:0]         cprod;
  logic                       curve_start;

  logic signed [9:0]          drv;
  logic signed [WIDE_W-1:0]   xwide;
  logic signed [24:0]         grad;
  logic                       grad_pos;
  logic                       sl_pos;
  logic                       sl_neg;
  logic                       rev;
  logic signed [25:0]         kx26;
  logic signed [25:0]         x26;
  logic signed [25:0]         y26;
  logic signed [25:0]         ky26;
  logic signed [25:0]         shift_r;
  logic signed [25:0]         shift_f;
  logic signed [25:0]         sc_r;
  logic signed [25:0]         sc_f;
  logic signed [24:0]         zsum;
  logic signed [17:0]         kys;
  logic signed [26:0]         ksh;
  logic signed [33:0]         ysum;
  logic                       cdone;
  logic signed [mhs_pkg::CURVE_W-1:0] cval;

  assign drv      = $signed({1'b0, 9'(cfg.drive) + 9'd4});
  assign xwide    = $signed({sprod, 16'd0}) >>> (SAMPLE_BITS + 2);
  assign grad     = {x[23], x} - {prev_input[23], prev_input};
  assign grad_pos = !grad[24] && (grad != 25'sd0);
  assign sl_pos   = !prev_slope[23] && (prev_slope != 24'sd0);
  assign sl_neg   = prev_slope[23];
  assign rev      = (grad_pos && sl_neg) || (grad[24] && sl_pos);

  assign kx26    = $signed({4'd0, cfg.knee_x});
  assign x26     = {{2{x[23]}}, x};
  assign y26     = {{2{curve_output[23]}}, curve_output};
  assign ky26    = $signed({9'd0, cfg.knee_y});
  assign shift_r = kx26 - x26;
  assign shift_f = -kx26 - x26;
  assign sc_r    = (ky26 + y26) >>> 1;
  assign sc_f    = (ky26 - y26) >>> 1;

  assign zsum = {x[23], x} + {input_shift[23], input_shift};
  assign kys  = from_rise ? $signed({1'b0, cfg.knee_y}) : -$signed({1'b0, cfg.knee_y});
  assign ksh  = {kprod[41], kprod[41:16]} - {{3{curve_output[23]}}, curve_output};
  assign ysum = {cprod[48], cprod[48:16]} - {{10{output_shift[23]}}, output_shift};

  assign y = curve_output;

  mhs_curve u_curve (
    .clk   (clk),
    .rst   (rst),
    .start (curve_start),
    .z     (z),
    .p     (cfg.p),
    .inv   (cfg.inv),
    .done  (cdone),
    .c     (cval)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= L_IDLE;
      done         <= 1'b0;
      curve_start  <= 1'b0;
      prev_input   <= '0;
      prev_slope   <= '0;
      curve_output <= '0;
      input_shift  <= '0;
      output_scale <= 24'sd65536;
      output_shift <= '0;
      anchor       <= 1'b0;
      from_rise    <= 1'b0;
    end else begin
      done        <= (state == L_OUT);
      curve_start <= (state == L_OSH);
      case (state)
        L_IDLE: begin
          if (start) begin
            sprod <= sample * drv;
            state <= L_X;
          end
        end
        L_X: begin
          x     <= sat24(64'(xwide));
          state <= L_ANCHOR;
        end
        L_ANCHOR: begin
          anchor <= rev;
          if (rev) begin
            from_rise <= sl_pos;
            if (sl_pos) begin
              input_shift  <= sat24(64'(shift_r));
              output_scale <= sat24(64'(sc_r));
            end else begin
              input_shift  <= sat24(64'(shift_f));
              output_scale <= sat24(64'(sc_f));
            end
          end
          prev_slope <= sat24(64'(grad));
          prev_input <= x;
          state      <= L_SHIFT;
        end
        L_SHIFT: begin
          z <= sat24(64'(zsum));
          if (anchor) begin
            kprod <= kys * output_scale;
          end
          state <= L_OSH;
        end
        L_OSH: begin
          if (anchor) begin
            output_shift <= sat24(64'(ksh));
          end
          state <= L_CURVE;
        end
        L_CURVE: begin
          if (cdone) begin
            cprod <= cval * output_scale;
            state <= L_OUT;
          end
        end
        L_OUT: begin
          curve_output <= sat24(64'(ysum));
          state        <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/magnetic_hysteresis_saturator.sv
// ----------------------------------------------------------------------------
// magnetic_hysteresis_saturator: stereo hysteresis distortion
// Parallel lanes, one per channel, each with its own curve unit; a merge
// stage applies the level gain, saturates and duplicates the mono result.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  s_tdata: left_sample, right_sample
//   m_*       out        m_tvalid/m_tready  m_tdata: left_out, right_out
//   cfg_*     in         cfg_wr_en          cfg_addr, cfg_wdata
//
// A frame runs from acceptance through the curve unit in each lane, which
// runs two 16-step log2 passes and two 16-step exp2 passes, one step per
// cycle; a zero curve argument skips all the curve passes, and a zero
// exponent term skips the second log2 pass. Lanes run side by side, so
// stereo costs no more than mono; the slower lane sets the frame time. A
// new request is taken only once the previous frame has been loaded into
// the output register; a finished result waits there while the next
// request is accepted, and the merge step stalls only while that register
// still holds a result nobody has taken. Reset is synchronous and restores
// the configuration, the control registers and the lane state; there is
// no clearing pass.
module magnetic_hysteresis_saturator #(
  parameter int CHANNELS    = mhs_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = mhs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [mhs_pkg::CFG_IDX_W-1:0]         cfg_addr,
  input  logic [mhs_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // left_sample, right_sample (from bit 0 up), zero padded to whole bytes
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // left_out, right_out (from bit 0 up), zero padded to whole bytes
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    m_tdata
);

  localparam int TDATA_W = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int LW_W    = 31 + SAMPLE_BITS;

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_RUN   = 2'd1;
  localparam logic [1:0] T_LEVEL = 2'd2;
  localparam logic [1:0] T_OUT   = 2'd3;

  localparam logic signed [LW_W-1:0] OUT_HI =
    $signed({{32{1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [LW_W-1:0] OUT_LO =
    $signed({{32{1'b1}}, {(SAMPLE_BITS-1){1'b0}}});

  mhs_pkg::mhs_cfg_t               cfg;
  logic [1:0]                      state;
  logic                            mono;
  logic [CHANNELS-1:0]             lane_start;
  logic [CHANNELS-1:0]             pending;
  logic signed [SAMPLE_BITS:0]     lane_in   [CHANNELS];
  logic signed [31:0]              lprod     [CHANNELS];

  logic                            accept;
  logic                            mono_in;
  logic signed [SAMPLE_BITS-1:0]   in_l;
  logic signed [SAMPLE_BITS-1:0]   in_r;
  logic signed [SAMPLE_BITS:0]     in_sum;
  logic signed [SAMPLE_BITS:0]     lane_sel  [CHANNELS];
  logic [CHANNELS-1:0]             start_mask;
  logic [CHANNELS-1:0]             lane_done;
  mhs_pkg::mhs_st_t                lane_y    [CHANNELS];
  logic signed [LW_W-1:0]          lw        [CHANNELS];
  logic [SAMPLE_BITS-1:0]          osamp     [CHANNELS];
  logic [SAMPLE_BITS-1:0]          out_l;
  logic [SAMPLE_BITS-1:0]          out_r;

  assign s_tready = (state == T_IDLE);
  assign accept   = s_tvalid && s_tready;

  // A single-lane build always runs the mono sum.
  assign mono_in = (CHANNELS == 1) || !cfg.stereo;
  assign in_l    = $signed(s_tdata[SAMPLE_BITS-1:0]);
  assign in_r    = $signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
  assign in_sum  = {in_l[SAMPLE_BITS-1], in_l} + {in_r[SAMPLE_BITS-1], in_r};

  always_comb begin
    for (int g = 0; g < CHANNELS; g++) begin
      if (g == 0) begin
        lane_sel[g]   = mono_in ? in_sum : {in_l[SAMPLE_BITS-1], in_l};
        start_mask[g] = 1'b1;
      end else begin
        lane_sel[g]   = {in_r[SAMPLE_BITS-1], in_r};
        start_mask[g] = !mono_in;
      end
    end
  end

  // Level gain is in quarters; the sample carries SAMPLE_BITS-1 fraction bits.
  always_comb begin
    for (int g = 0; g < CHANNELS; g++) begin
      lw[g] = $signed({lprod[g], {(SAMPLE_BITS-1){1'b0}}}) >>> 18;
      if (lw[g] > OUT_HI) begin
        osamp[g] = OUT_HI[SAMPLE_BITS-1:0];
      end else if (lw[g] < OUT_LO) begin
        osamp[g] = OUT_LO[SAMPLE_BITS-1:0];
      end else begin
        osamp[g] = lw[g][SAMPLE_BITS-1:0];
      end
    end
  end

  assign out_l = osamp[0];
  assign out_r = mono ? osamp[0] : osamp[CHANNELS-1];

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive  <= mhs_pkg::DRIVE_RST;
      cfg.p      <= mhs_pkg::EXPONENT_RST;
      cfg.inv    <= mhs_pkg::INV_EXP_RST;
      cfg.knee_x <= mhs_pkg::KNEE_X_RST;
      cfg.knee_y <= mhs_pkg::KNEE_Y_RST;
      cfg.level  <= mhs_pkg::LEVEL_RST;
      cfg.stereo <= mhs_pkg::STEREO_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        mhs_pkg::REG_DRIVE:    cfg.drive  <= cfg_wdata[7:0];
        mhs_pkg::REG_EXPONENT: cfg.p      <= cfg_wdata[14:0];
        mhs_pkg::REG_INV_EXP:  cfg.inv    <= cfg_wdata[18:0];
        mhs_pkg::REG_KNEE_X:   cfg.knee_x <= cfg_wdata[21:0];
        mhs_pkg::REG_KNEE_Y:   cfg.knee_y <= cfg_wdata[16:0];
        mhs_pkg::REG_LEVEL:    cfg.level  <= cfg_wdata[6:0];
        mhs_pkg::REG_STEREO:   cfg.stereo <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: accept a frame, run the lanes, apply the level, hand over.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      mono       <= 1'b0;
      lane_start <= '0;
      pending    <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      lane_start <= accept ? start_mask : '0;
      // The merge step reloads the output register itself when it fires.
      if (m_tvalid && m_tready && state != T_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept) begin
            for (int g = 0; g < CHANNELS; g++) begin
              lane_in[g] <= lane_sel[g];
            end
            mono    <= mono_in;
            pending <= start_mask;
            state   <= T_RUN;
          end
        end
        T_RUN: begin
          pending <= pending & ~lane_done;
          if (pending == '0) begin
            state <= T_LEVEL;
          end
        end
        T_LEVEL: begin
          for (int g = 0; g < CHANNELS; g++) begin
            lprod[g] <= lane_y[g] * $signed({1'b0, cfg.level});
          end
          state <= T_OUT;
        end
        T_OUT: begin
          // The output register may still hold a result nobody has taken.
          if (!m_tvalid || m_tready) begin
            m_tdata  <= TDATA_W'({out_r, out_l});
            m_tvalid <= 1'b1;
            state    <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    mhs_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .start  (lane_start[g]),
      .sample (lane_in[g]),
      .cfg    (cfg),
      .done   (lane_done[g]),
      .y      (lane_y[g])
    );
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == T_IDLE) |-> (pending == '0))
    else $error("lanes still pending while idle");

  a_done_only_pending: assert property (@(posedge clk) disable iff (rst)
    ((lane_done & ~pending) == '0))
    else $error("lane finished without a frame in flight");

  a_left_lane_always: assert property (@(posedge clk) disable iff (rst)
    (lane_start != '0) |-> lane_start[0])
    else $error("a lane started without the left lane");

  a_result_from_merge: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == T_OUT))
    else $error("result presented outside the merge step");

endmodule

>>> tb/sv/magnetic_hysteresis_saturator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// magnetic_hysteresis_saturator_test: self-checking bench for the saturator
// Drives stereo frames through the request stream with random gaps on both
// sides, predicts every result with a behavioural copy of the hysteresis
// lanes, and compares each returned frame field by field.
// ----------------------------------------------------------------------------
module magnetic_hysteresis_saturator_test;

  localparam int SB      = 16;
  localparam int DW      = 32;
  localparam int IW      = mhs_pkg::CFG_IDX_W;
  localparam int CW      = mhs_pkg::CFG_DATA_W;
  localparam int WD_LIMIT = 20000;
  localparam int NUM_RANDOM = 1300;
  localparam longint ST_HI = 64'sd8388607;
  localparam longint ST_LO = -64'sd8388608;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [IW-1:0]         cfg_addr = '0;
  logic [CW-1:0]         cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // left_sample, right_sample from bit 0 up
  logic [DW-1:0]         s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // left_out, right_out from bit 0 up
  logic [DW-1:0]         m_tdata;

  magnetic_hysteresis_saturator u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor's copy of the registers and of each lane's anchoring state.
  longint drive_r, p_r, inv_r, kx_r, ky_r, level_r, stereo_r;
  longint last_x[2], last_grad[2], last_y[2], x_shift[2], y_scale[2], y_shift[2];
  longint roots[16];

  logic [DW-1:0] expected_frames[$];
  int  errors = 0;
  int  frames_checked = 0;
  int  idle_cycles = 0;
  bit  timed_out = 1'b0;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp24(longint v);
    return v > ST_HI ? ST_HI : (v < ST_LO ? ST_LO : v);
  endfunction

  function automatic longint floor_root(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Fractional log2 of m/2^30 with m in [2^30, 2^31], by repeated squaring.
  function automatic longint log2_frac(longint m);
    longint acc;
    acc = 0;
    if (m >= (64'sd1 << 31)) return 65536;
    for (int i = 1; i <= 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'sd1 << 31)) begin
        m = m >> 1;
        acc = acc | (64'sd1 << (16 - i));
      end
    end
    return acc;
  endfunction

  function automatic longint log2_val(longint a);
    int k;
    k = 0;
    while (k < 62 && (a >> (k + 1)) != 0) k++;
    return longint'(k - 16) * 65536 + log2_frac(a << (30 - k));
  endfunction

  function automatic longint pow2_val(longint e, int fb);
    longint n, f, r, sh;
    n = floor_shr(e, 16);
    f = e - n * 65536;
    r = 64'sd1 << 30;
    for (int i = 0; i < 16; i++)
      if ((f >> (15 - i)) & 1) r = (r * roots[i]) >> 30;
    sh = 30 - fb - n;
    if (sh >= 63) return 0;
    if (sh < 0) return r;
    return r >> sh;
  endfunction

  // Odd curve z / (1 + |z|^p)^(1/p) evaluated in the log domain.
  function automatic longint knee_curve(longint z);
    longint a, lg, t, at, sp, u, mag;
    a = z < 0 ? -z : z;
    if (a == 0) return 0;
    lg  = log2_val(a);
    t   = floor_shr(lg * p_r, 12);
    at  = t < 0 ? -t : t;
    sp  = (t > 0 ? t : 0) + log2_frac((64'sd1 << 30) + pow2_val(-at, 30));
    u   = floor_shr(sp * inv_r, 16);
    mag = pow2_val(lg - u, 16);
    return z < 0 ? -mag : mag;
  endfunction

  function automatic longint drive_scale(longint s);
    return clamp24(floor_shr(s * (4 + drive_r) * 65536, SB + 2));
  endfunction

  function automatic longint lane_advance(int ln, longint x);
    longint grad, sl, y, sc;
    grad = x - last_x[ln];
    sl   = last_grad[ln];
    y    = last_y[ln];
    // A reversal of the slope re-anchors the curve at one of the knees.
    if ((grad > 0 && sl < 0) || (grad < 0 && sl > 0)) begin
      if (sl > 0) begin
        x_shift[ln] = clamp24(kx_r - x);
        sc = clamp24(floor_shr(ky_r + y, 1));
        y_shift[ln] = clamp24(floor_shr(ky_r * sc, 16) - y);
      end else begin
        x_shift[ln] = clamp24(-kx_r - x);
        sc = clamp24(floor_shr(ky_r - y, 1));
        y_shift[ln] = clamp24(floor_shr(-ky_r * sc, 16) - y);
      end
      y_scale[ln] = sc;
    end
    y = knee_curve(clamp24(x + x_shift[ln]));
    y = clamp24(floor_shr(y * y_scale[ln], 16) - y_shift[ln]);
    last_grad[ln] = clamp24(grad);
    last_x[ln] = x;
    last_y[ln] = y;
    return y;
  endfunction

  function automatic logic [SB-1:0] level_out(longint y);
    longint v;
    v = floor_shr(y * level_r * (64'sd1 << (SB - 1)), 18);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SB-1:0];
  endfunction

  function automatic logic [DW-1:0] saturate_frame(logic [DW-1:0] frm);
    longint sl, sr, yl, yr;
    sl = longint'($signed(frm[15:0]));
    sr = longint'($signed(frm[31:16]));
    if (stereo_r != 0) begin
      yl = lane_advance(0, drive_scale(sl));
      yr = lane_advance(1, drive_scale(sr));
    end else begin
      // Mono: the left lane carries the sum and the right lane stands still.
      yl = lane_advance(0, drive_scale(sl + sr));
      yr = yl;
    end
    return {level_out(yr), level_out(yl)};
  endfunction

  task automatic reset_model();
    drive_r = mhs_pkg::DRIVE_RST; p_r = mhs_pkg::EXPONENT_RST;
    inv_r = mhs_pkg::INV_EXP_RST; kx_r = mhs_pkg::KNEE_X_RST;
    ky_r = mhs_pkg::KNEE_Y_RST; level_r = mhs_pkg::LEVEL_RST;
    stereo_r = mhs_pkg::STEREO_RST;
    for (int i = 0; i < 2; i++) begin
      last_x[i] = 0; last_grad[i] = 0; last_y[i] = 0;
      x_shift[i] = 0; y_scale[i] = 65536; y_shift[i] = 0;
    end
  endtask

  // Holds the write for one edge; the caller drops the enable afterwards.
  task automatic write_reg(logic [IW-1:0] idx, longint val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[CW-1:0];
    @(posedge clk);
    case (idx)
      mhs_pkg::REG_DRIVE:    drive_r  = val & 8'hFF;
      mhs_pkg::REG_EXPONENT: p_r      = val & 15'h7FFF;
      mhs_pkg::REG_INV_EXP:  inv_r    = val & 19'h7FFFF;
      mhs_pkg::REG_KNEE_X:   kx_r     = val & 22'h3FFFFF;
      mhs_pkg::REG_KNEE_Y:   ky_r     = val & 17'h1FFFF;
      mhs_pkg::REG_LEVEL:    level_r  = val & 7'h7F;
      mhs_pkg::REG_STEREO:   stereo_r = val & 1;
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 150);
  endfunction

  // Offers one request, with a random gap first, and predicts its result.
  // With no gap the valid stays high and the next request follows directly.
  task automatic send_frame(logic [DW-1:0] frm);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= frm;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_frames.push_back(saturate_frame(frm));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0 && !timed_out) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] rand_frame(int shape);
    logic [15:0] l, r;
    case (shape)
      0: begin l = $urandom; r = $urandom; end
      // Small random values so the slope reverses often with small steps.
      1: begin l = $urandom_range(0, 4000) - 2000; r = $urandom_range(0, 600) - 300; end
      default: begin
        l = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        r = $urandom_range(0, 1) ? 16'h0000 : 16'h7FFF;
      end
    endcase
    return {r, l};
  endfunction

  // Receiver side: random back-pressure and the result comparison.
  always @(posedge clk) begin
    logic [DW-1:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_tdata);
          errors++;
        end else begin
          want = expected_frames.pop_front();
          frames_checked++;
          if (want[15:0] !== m_tdata[15:0]) begin
            $display("%0t: left_out expected %0d got %0d", $time,
                     $signed(want[15:0]), $signed(m_tdata[15:0]));
            errors++;
          end
          if (want[31:16] !== m_tdata[31:16]) begin
            $display("%0t: right_out expected %0d got %0d", $time,
                     $signed(want[31:16]), $signed(m_tdata[31:16]));
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 40) == 0);
    end
  end

  // Watchdog on busy cycles in which neither side moves a request or a result.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst ||
        (expected_frames.size() == 0 && !s_tvalid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Directed rows: samples plus, where obvious, the result. The first two
  // rows follow reset: zero in gives zero out; a zero step never re-anchors.
  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    bit          known;
    logic [31:0] result;
  } vector_row_t;

  vector_row_t directed[] = '{
    '{16'h0000, 16'h0000, 1'b1, 32'h0000_0000},
    '{16'h0000, 16'h0000, 1'b1, 32'h0000_0000},
    '{16'h7FFF, 16'h8000, 1'b0, 32'h0},
    '{16'h7FFF, 16'h8000, 1'b0, 32'h0},
    '{16'h8000, 16'h7FFF, 1'b0, 32'h0},
    '{16'h0001, 16'hFFFF, 1'b0, 32'h0},
    '{16'h4000, 16'hC000, 1'b0, 32'h0},
    '{16'h2000, 16'hE000, 1'b0, 32'h0},
    '{16'h5555, 16'hAAAA, 1'b0, 32'h0},
    '{16'hAAAA, 16'h5555, 1'b0, 32'h0},
    '{16'h0100, 16'h0100, 1'b0, 32'h0},
    '{16'hFF00, 16'h0200, 1'b0, 32'h0}
  };

  // Register settings walked between phases: each column is one register.
  longint settings[5][7] = '{
    '{4,   1024,  262144, 32768,   0,     0,   1},
    '{131, 26010, 10308,  2146304, 65536, 127, 0},
    '{255, 32767, 524287, 4194303, 131071, 127, 1},
    '{20,  4096,  65536,  65536,   40000, 4,   0},
    '{0,   0,     0,      0,       65536, 96,  1}
  };

  initial begin
    logic [31:0] frm, got_expect;
    int          per_phase;
    for (int i = 0; i < 16; i++) roots[i] = 0;
    roots[0] = floor_root(64'sd2 << 60);
    for (int i = 1; i < 16; i++) roots[i] = floor_root(roots[i-1] << 30);
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      frm = {directed[i].right, directed[i].left};
      send_frame(frm);
      // Overwrite the prediction with the typed-in value where one is given.
      if (directed[i].known) begin
        got_expect = expected_frames.pop_back();
        if (got_expect !== directed[i].result)
          $display("%0t: table row %0d disagrees with predictor", $time, i);
        expected_frames.push_back(directed[i].result);
      end
    end
    drain();

    per_phase = NUM_RANDOM / 6;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        for (int r = 0; r < 7; r++)
          write_reg(IW'(r), settings[ph-1][r]);
        cfg_wr_en <= 1'b0;
      end
      for (int n = 0; n < per_phase; n++) begin
        int rr;
        rr = $urandom_range(0, 9);
        send_frame(rand_frame(rr < 4 ? 0 : (rr < 9 ? 1 : 2)));
      end
      drain();
    end

    $display("%0d frames checked over the reset setting and five register sets,",
             frames_checked);
    $display("stereo and mono, extreme drives, exponents and knees.");
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
